// File: rtl/core/sliding_window_median_filter_core_defines.svh
// assertion macros shared by the checker files
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define SWMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/swmf_pkg.sv
`timescale 1ns / 1ps
package swmf_pkg;

	// sizing
	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 32;
	localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W       = $clog2(MAX_WINDOW + 1);

	// fixed port widths
	localparam int DATA_W     = 32;
	localparam int CFG_LEN_W  = 5;
	localparam int CFG_RANK_W = 4;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam int LEN_RESET  = 5;
	localparam int RANK_RESET = 2;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [SAMPLE_BITS-1:0] smp_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_WINDOW_LENGTH = cfg_idx_t'(0);
	localparam cfg_idx_t REG_OUTPUT_RANK   = cfg_idx_t'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// sequencer requests to the window store
	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		smp_t wr_data;
		logic rd_en;
		idx_t rd_addr_a;
		idx_t rd_addr_b;
	} win_req_t;

endpackage

// File: rtl/core/swmf_cmp.sv
`timescale 1ns / 1ps
// shared rank comparator: does entry b come ahead of entry a in the sorted order
// ties are broken by slot index so that every entry gets a distinct position
module swmf_cmp (
	input  swmf_pkg::smp_t val_a,
	input  swmf_pkg::smp_t val_b,
	input  swmf_pkg::idx_t idx_a,
	input  swmf_pkg::idx_t idx_b,
	output logic           ahead
);

	always_comb begin
		ahead = (val_b < val_a) || ((val_b == val_a) && (idx_b < idx_a));
	end

endmodule

// File: rtl/core/swmf_window.sv
`timescale 1ns / 1ps
// circular sample store, one write port and two registered read ports
module swmf_window (
	input  logic             clk,
	input  logic             arst_n,
	input  swmf_pkg::win_req_t req,
	output swmf_pkg::smp_t   rd_a,
	output swmf_pkg::smp_t   rd_b
);

	swmf_pkg::smp_t                 mem_q [swmf_pkg::MAX_WINDOW];
	logic [swmf_pkg::MAX_WINDOW-1:0] valid_q;
	swmf_pkg::smp_t                 rd_a_q;
	swmf_pkg::smp_t                 rd_b_q;

	// entry valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_a_q <= valid_q[req.rd_addr_a] ? mem_q[req.rd_addr_a] : '0;
			rd_b_q <= valid_q[req.rd_addr_b] ? mem_q[req.rd_addr_b] : '0;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// File: rtl/core/swmf_ctrl.sv
`timescale 1ns / 1ps
// sequencer: config registers, write pointer, pairwise scan and result register
module swmf_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swmf_pkg::DATA_W-1:0]       sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swmf_pkg::DATA_W-1:0]       filtered,
	input  logic                              cfg_write,
	input  swmf_pkg::cfg_idx_t                cfg_index,
	input  logic [swmf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output swmf_pkg::win_req_t                win_req,
	input  swmf_pkg::smp_t                    rd_a,
	output swmf_pkg::idx_t                    cmp_idx_a,
	output swmf_pkg::idx_t                    cmp_idx_b,
	input  logic                              cmp_ahead
);

	swmf_pkg::state_t                   state_q;
	swmf_pkg::state_t                   state_d;
	logic [swmf_pkg::CFG_LEN_W-1:0]     win_len_q;
	logic [swmf_pkg::CFG_RANK_W-1:0]    out_rank_q;
	swmf_pkg::idx_t                     wr_pos_q;
	swmf_pkg::idx_t                     i_q;
	swmf_pkg::idx_t                     j_q;
	swmf_pkg::idx_t                     i_s1;
	swmf_pkg::idx_t                     j_s1;
	logic                               vld_s1;
	logic                               row_end_s1;
	swmf_pkg::idx_t                     cnt_q;
	swmf_pkg::smp_t                     result_q;
	logic                               out_valid_q;
	logic [swmf_pkg::DATA_W-1:0]        filtered_q;

	swmf_pkg::len_t                     len;
	swmf_pkg::idx_t                     last;
	swmf_pkg::idx_t                     rank;
	swmf_pkg::idx_t                     wr_slot;
	swmf_pkg::idx_t                     wr_next;
	swmf_pkg::idx_t                     cnt_sum;
	logic                               accept;
	logic                               issue;
	logic                               load_out;
	logic                               scan_end;

	// effective length and rank
	always_comb begin
		if (win_len_q == '0) begin
			len = swmf_pkg::len_t'(1);
		end else if (32'(win_len_q) > 32'(swmf_pkg::MAX_WINDOW)) begin
			len = swmf_pkg::len_t'(swmf_pkg::MAX_WINDOW);
		end else begin
			len = swmf_pkg::len_t'(win_len_q);
		end
		last = swmf_pkg::idx_t'(len - swmf_pkg::len_t'(1));
		if (32'(out_rank_q) > 32'(last)) begin
			rank = last;
		end else begin
			rank = swmf_pkg::idx_t'(out_rank_q);
		end
	end

	// write slot and following position
	always_comb begin
		if (swmf_pkg::len_t'(wr_pos_q) >= len) begin
			wr_slot = '0;
		end else begin
			wr_slot = wr_pos_q;
		end
		if (swmf_pkg::len_t'(wr_slot) + swmf_pkg::len_t'(1) >= len) begin
			wr_next = '0;
		end else begin
			wr_next = swmf_pkg::idx_t'(wr_slot + swmf_pkg::idx_t'(1));
		end
	end

	assign scan_end = (i_q == last) && (j_q == last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swmf_pkg::ST_IDLE: begin
				if (in_valid) state_d = swmf_pkg::ST_SCAN;
			end
			swmf_pkg::ST_SCAN: begin
				if (scan_end) state_d = swmf_pkg::ST_DRAIN;
			end
			swmf_pkg::ST_DRAIN: begin
				state_d = swmf_pkg::ST_DONE;
			end
			swmf_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = swmf_pkg::ST_IDLE;
			end
			default: state_d = swmf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			swmf_pkg::ST_IDLE:  in_ready = 1'b1;
			swmf_pkg::ST_SCAN:  issue    = 1'b1;
			swmf_pkg::ST_DRAIN: ;
			swmf_pkg::ST_DONE:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q  <= swmf_pkg::CFG_LEN_W'(swmf_pkg::LEN_RESET);
			out_rank_q <= swmf_pkg::CFG_RANK_W'(swmf_pkg::RANK_RESET);
		end else if (cfg_write) begin
			unique case (cfg_index)
				swmf_pkg::REG_WINDOW_LENGTH: win_len_q <= cfg_data[swmf_pkg::CFG_LEN_W-1:0];
				swmf_pkg::REG_OUTPUT_RANK:   out_rank_q <= cfg_data[swmf_pkg::CFG_RANK_W-1:0];
				default: ;
			endcase
		end
	end

	// write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
		end else if (accept) begin
			wr_pos_q <= wr_next;
		end
	end

	// pair counters, b sweeps fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (accept) begin
			i_q <= '0;
			j_q <= '0;
		end else if (issue) begin
			if (j_q == last) begin
				j_q <= '0;
				i_q <= swmf_pkg::idx_t'(i_q + swmf_pkg::idx_t'(1));
			end else begin
				j_q <= swmf_pkg::idx_t'(j_q + swmf_pkg::idx_t'(1));
			end
		end
	end

	// compare stage, lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			i_s1       <= i_q;
			j_s1       <= j_q;
			row_end_s1 <= (j_q == last);
		end
	end

	assign cmp_idx_a = i_s1;
	assign cmp_idx_b = j_s1;
	assign cnt_sum   = swmf_pkg::idx_t'(cnt_q + swmf_pkg::idx_t'(cmp_ahead));

	// count entries ranked ahead of entry a, keep a when its position is the rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (vld_s1) begin
			cnt_q <= row_end_s1 ? '0 : cnt_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && row_end_s1 && (cnt_sum == rank)) begin
			result_q <= rd_a;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered_q <= swmf_pkg::DATA_W'(result_q);
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	// window store requests
	always_comb begin
		win_req.wr_en     = accept;
		win_req.wr_addr   = wr_slot;
		win_req.wr_data   = swmf_pkg::smp_t'(sample);
		win_req.rd_en     = issue;
		win_req.rd_addr_a = i_q;
		win_req.rd_addr_b = j_q;
	end

endmodule

// File: rtl/core/sliding_window_median_filter_core.sv
`timescale 1ns / 1ps
// running rank (median) filter over a circular window of recent samples
// input channel: in_valid / in_ready with sample; one transfer per sample
// output channel: out_valid / out_ready with filtered; one result per sample
// config: cfg_write with cfg_index 0 = window length (clamped 1..16),
//   index 1 = output rank (clamped to length - 1); write only while idle
// each sample overwrites the oldest slot, then every pair of window entries
//   goes through one shared comparator, one pair per cycle, counting how many
//   entries rank ahead of each one; the entry whose count equals the rank wins
// a new sample is not taken until the comparator sweep for the last one is done;
//   in_ready is low from the input transfer until the result is loaded
// a finished result waits in an output register, so the next sample can be
//   taken and ranked while the receiver stalls; the block only holds before
//   loading a second result over one not yet transferred
// reset: window reads as all zero, write position 0, length 5, rank 2,
//   no result pending
module sliding_window_median_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [swmf_pkg::DATA_W-1:0]     sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swmf_pkg::DATA_W-1:0]     filtered,
	input  logic                            cfg_write,
	input  swmf_pkg::cfg_idx_t              cfg_index,
	input  logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data
);

	swmf_pkg::win_req_t win_req;
	swmf_pkg::smp_t     rd_a;
	swmf_pkg::smp_t     rd_b;
	swmf_pkg::idx_t     cmp_idx_a;
	swmf_pkg::idx_t     cmp_idx_b;
	logic               cmp_ahead;

	// sample store
	swmf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (win_req),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	// shared comparator
	swmf_cmp u_cmp (
		.val_a (rd_a),
		.val_b (rd_b),
		.idx_a (cmp_idx_a),
		.idx_b (cmp_idx_b),
		.ahead (cmp_ahead)
	);

	// sequencer
	swmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.win_req   (win_req),
		.rd_a      (rd_a),
		.cmp_idx_a (cmp_idx_a),
		.cmp_idx_b (cmp_idx_b),
		.cmp_ahead (cmp_ahead)
	);

endmodule

// File: rtl/core/swmf_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_median_filter_core_defines.svh"
// port-level checks on the filter core
module swmf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [swmf_pkg::DATA_W-1:0]     filtered
);

	// a waiting result holds until its transfer
	`SWMF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(filtered), "result changed while stalled")

	// one sample at a time: input closes after a transfer
	`SWMF_ASSERT_NXT(a_in_close, clk, arst_n, in_valid && in_ready, !in_ready,
		"input still open after a transfer")

	// a result never appears straight after a sample transfer
	`SWMF_ASSERT_IMP(a_no_early_result, clk, arst_n, $rose(out_valid),
		!$past(in_valid && in_ready), "result too soon after input")

	// input reopens only together with a loaded result
	`SWMF_ASSERT_IMP(a_reopen_with_result, clk, arst_n, $rose(in_ready), out_valid,
		"input reopened without a result")

endmodule

bind sliding_window_median_filter_core swmf_checker u_swmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered)
);

// File: sim/sliding_window_median_filter_core_tb.sv
`timescale 1ns / 1ps
module sliding_window_median_filter_core_tb;

	localparam int TARGET_SAMPLES = 1150;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [swmf_pkg::DATA_W-1:0]     sample;
	logic                            out_valid;
	logic                            out_ready;
	logic [swmf_pkg::DATA_W-1:0]     filtered;
	logic                            cfg_write;
	swmf_pkg::cfg_idx_t              cfg_index;
	logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data;

	// window copy and register shadows for prediction
	swmf_pkg::smp_t                  window_model [swmf_pkg::MAX_WINDOW];
	int                              next_slot;
	logic [swmf_pkg::CFG_LEN_W-1:0]  length_reg;
	logic [swmf_pkg::CFG_RANK_W-1:0] rank_reg;

	logic [swmf_pkg::DATA_W-1:0] filtered_q [$];
	int unsigned                 samples_sent;
	int unsigned                 results_seen;
	int unsigned                 reg_writes;
	int unsigned                 mismatch_count;
	int unsigned                 sink_hold_cycles;
	bit                          no_idle;

	sliding_window_median_filter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#30_000_000;
		$display("sliding_window_median_filter_core test failed");
		$finish;
	end

	function automatic void clear_window_model();
		for (int i = 0; i < swmf_pkg::MAX_WINDOW; i++) begin
			window_model[swmf_pkg::idx_t'(i)] = '0;
		end
		next_slot  = 0;
		length_reg = swmf_pkg::CFG_LEN_W'(swmf_pkg::LEN_RESET);
		rank_reg   = swmf_pkg::CFG_RANK_W'(swmf_pkg::RANK_RESET);
	endfunction

	// insert the sample into the window copy and pick the ranked entry
	function automatic logic [swmf_pkg::DATA_W-1:0] predict_filtered(
			input logic [swmf_pkg::DATA_W-1:0] value);
		int             len;
		int             pick;
		swmf_pkg::smp_t ordered [swmf_pkg::MAX_WINDOW];
		swmf_pkg::smp_t swap;
		swmf_pkg::idx_t lo;
		swmf_pkg::idx_t hi;
		len = int'(length_reg);
		if (len < 1) len = 1;
		if (len > swmf_pkg::MAX_WINDOW) len = swmf_pkg::MAX_WINDOW;
		// a shortened window sends a stale write position back to slot 0
		if (next_slot >= len) next_slot = 0;
		window_model[swmf_pkg::idx_t'(next_slot)] = swmf_pkg::smp_t'(value);
		next_slot++;
		if (next_slot >= len) next_slot = 0;
		for (int i = 0; i < len; i++) begin
			lo          = swmf_pkg::idx_t'(i);
			ordered[lo] = window_model[lo];
		end
		for (int i = 0; i < len; i++) begin
			for (int j = 0; j + 1 < len - i; j++) begin
				lo = swmf_pkg::idx_t'(j);
				hi = swmf_pkg::idx_t'(j + 1);
				if (ordered[lo] > ordered[hi]) begin
					swap        = ordered[lo];
					ordered[lo] = ordered[hi];
					ordered[hi] = swap;
				end
			end
		end
		pick = int'(rank_reg);
		if (pick > len - 1) pick = len - 1;
		return swmf_pkg::DATA_W'(ordered[swmf_pkg::idx_t'(pick)]);
	endfunction

	function automatic int unsigned draw_gap();
		if (no_idle) return 0;
		return $urandom_range(0, 14);
	endfunction

	// samples biased towards ties and extremes
	function automatic logic [swmf_pkg::DATA_W-1:0] draw_sample();
		case ($urandom_range(0, 6))
			0: return swmf_pkg::DATA_W'($urandom_range(0, 7));
			1: return {swmf_pkg::DATA_W{1'b1}} - swmf_pkg::DATA_W'($urandom_range(0, 7));
			2: return '0;
			3: return swmf_pkg::DATA_W'(1) << $urandom_range(0, swmf_pkg::DATA_W - 1);
			default: return swmf_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// one input transfer, prediction taken at acceptance
	task automatic send_sample(input logic [swmf_pkg::DATA_W-1:0] value);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do @(posedge clk); while (!(in_valid && in_ready));
		filtered_q.push_back(predict_filtered(value));
		samples_sent++;
	endtask

	// stop offering and wait until every result has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input swmf_pkg::cfg_idx_t idx,
			input logic [swmf_pkg::CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == swmf_pkg::REG_WINDOW_LENGTH) begin
			length_reg = value[swmf_pkg::CFG_LEN_W-1:0];
		end else if (idx == swmf_pkg::REG_OUTPUT_RANK) begin
			rank_reg = value[swmf_pkg::CFG_RANK_W-1:0];
		end
		reg_writes++;
	endtask

	task automatic configure(input logic [swmf_pkg::CFG_DATA_W-1:0] len_val,
			input logic [swmf_pkg::CFG_DATA_W-1:0] rank_val);
		drain_results();
		write_reg(swmf_pkg::REG_WINDOW_LENGTH, len_val);
		write_reg(swmf_pkg::REG_OUTPUT_RANK, rank_val);
	endtask

	// reset values: the window starts as zeros that the samples overwrite until it is full
	task automatic test_reset_window();
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
	endtask

	// length and rank clamping, stale write position, hidden entries
	task automatic test_length_clamp();
		// zero length acts as one, rank beyond it clamps
		configure(5'd0, 5'd31);
		send_sample(32'h5555_5555);
		send_sample(32'hAAAA_AAAA);
		// largest length and rank
		configure(5'd31, 5'd15);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'hAAAA_AAAA);
		// length just over the maximum, rank bit above the field dropped
		configure(5'd17, 5'b10000);
		send_sample(32'h0000_0002);
		// shrink below the write position, rank past the short window
		configure(5'd3, 5'd14);
		send_sample(32'h1234_5678);
		send_sample(32'hFEDC_BA98);
		// grow again so the untouched entries come back
		configure(5'd16, 5'd8);
		send_sample(32'h0000_0003);
		send_sample(32'hFFFF_FFFE);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		configure(5'd2, 5'd1);
		no_idle          = 1'b1;
		sink_hold_cycles = 400;
		for (int i = 0; i < 20; i++) send_sample(draw_sample());
		drain_results();
		no_idle = 1'b0;
	endtask

	// random settings, each followed by a burst of random samples
	task automatic test_random_phases();
		int unsigned                     burst;
		logic [swmf_pkg::CFG_DATA_W-1:0] len_val;
		logic [swmf_pkg::CFG_DATA_W-1:0] rank_val;
		while (samples_sent < TARGET_SAMPLES) begin
			drain_results();
			case ($urandom_range(0, 9))
				0: len_val = 5'd0;
				1: len_val = 5'd16;
				2: len_val = swmf_pkg::CFG_DATA_W'($urandom_range(17, 31));
				3: len_val = 5'd1;
				default: len_val = swmf_pkg::CFG_DATA_W'($urandom_range(1, 8));
			endcase
			if ($urandom_range(0, 1) == 0) begin
				rank_val = swmf_pkg::CFG_DATA_W'($urandom_range(0, 31));
			end else begin
				rank_val = (len_val == 0) ? '0 : swmf_pkg::CFG_DATA_W'((len_val - 1) / 2);
			end
			case ($urandom_range(0, 3))
				0: write_reg(swmf_pkg::REG_WINDOW_LENGTH, len_val);
				1: write_reg(swmf_pkg::REG_OUTPUT_RANK, rank_val);
				default: begin
					write_reg(swmf_pkg::REG_WINDOW_LENGTH, len_val);
					write_reg(swmf_pkg::REG_OUTPUT_RANK, rank_val);
				end
			endcase
			no_idle = ($urandom_range(0, 5) == 0);
			burst   = $urandom_range(20, 70);
			for (int i = 0; i < burst; i++) send_sample(draw_sample());
		end
		no_idle = 1'b0;
	endtask

	// receiver: random stall per result, plus any long hold-off requested
	initial begin : result_sink
		int unsigned gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap() + sink_hold_cycles;
			sink_hold_cycles = 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin : filtered_check
		logic [swmf_pkg::DATA_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (filtered_q.size() == 0) begin
				$error("filtered result %h with no sample outstanding", filtered);
				mismatch_count++;
			end else begin
				want = filtered_q.pop_front();
				if (filtered !== want) begin
					$error("filtered mismatch: expected %h, actual %h", want, filtered);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		sample           <= '0;
		cfg_write        <= 1'b0;
		cfg_index        <= swmf_pkg::REG_WINDOW_LENGTH;
		cfg_data         <= '0;
		samples_sent     = 0;
		results_seen     = 0;
		reg_writes       = 0;
		mismatch_count   = 0;
		sink_hold_cycles = 0;
		no_idle          = 1'b0;
		clear_window_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_length_clamp();
		test_backpressure();
		test_random_phases();

		drain_results();
		repeat (300) @(posedge clk);
		$display("covered %0d samples and %0d filtered results over %0d register writes,",
			samples_sent, results_seen, reg_writes);
		$display("window lengths 0 to 31, clamped ranks, long receiver hold-off");
		if (mismatch_count == 0 && filtered_q.size() == 0) begin
			$display("sliding_window_median_filter_core test passed");
		end else begin
			$display("sliding_window_median_filter_core test failed");
		end
		$finish;
	end

endmodule
